FILE: design/iss_pkg.sv
// Package for the insertion sorter: payload types, cell control and state encoding.
`timescale 1ns / 1ps

package iss_pkg;

    localparam int VALUE_BITS = 31;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  last_item;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_BITS-1:0] sorted_value;
        logic                  last_result;
        logic                  overflow;
    } t_out_item;

    typedef struct packed {
        logic                  insert;
        logic                  shift;
        logic [VALUE_BITS-1:0] value;
    } t_cell_ctl;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

endpackage

FILE: design/iss_cell.sv
// One cell of the sorting chain: holds one stored value and trades it with its neighbors.
`timescale 1ns / 1ps

module iss_cell
    import iss_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [CW-1:0]         i_count,
    input  logic [VALUE_BITS-1:0] i_below_val,
    input  logic                  i_below_gt,
    input  logic [VALUE_BITS-1:0] i_above_val,
    output logic [VALUE_BITS-1:0] o_val,
    output logic                  o_gt
);

    logic [VALUE_BITS-1:0] r_val;
    logic [VALUE_BITS-1:0] n_val;
    logic                  w_occupied;
    logic                  w_open_slot;

    assign w_occupied  = i_count > CW'(IDX);
    assign w_open_slot = i_count == CW'(IDX);
    assign o_gt        = w_occupied && (r_val > i_ctl.value);
    assign o_val       = r_val;

    always_comb begin
        n_val = r_val;
        priority if (i_ctl.shift) begin
            n_val = i_above_val;
        end else if (i_ctl.insert && i_below_gt) begin
            n_val = i_below_val;
        end else if (i_ctl.insert && (o_gt || w_open_slot)) begin
            n_val = i_ctl.value;
        end else begin
            n_val = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

FILE: design/insertion_sorter_unit.sv
// Top level of the insertion sorter: cell chain, fill count, drain sequencer and output register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------
//  input   | in        | i_in_valid / o_in_ready | i_in_data  (t_in_item)
//  output  | out       | o_out_valid / i_out_ready | o_out_data (t_out_item)
//
// Fill: one item per cycle; every cell compares and shifts in parallel.
// Drain: a run of n results leaves by n shifts down the chain, one result per shift;
//   the input is held off during the drain and reopens after its final item.
// Output stalls hold the drain; the output register frees the input side.
// Reset (synchronous, active low) clears the count, dropped flag, state and output valid.
`timescale 1ns / 1ps

module insertion_sorter_unit
    import iss_pkg::*;
#(
    parameter int MAX_ITEMS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int CW = $clog2(MAX_ITEMS + 1);

    t_state                r_state;
    t_state                n_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_drop;
    logic                  n_drop;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_out_item             r_out;
    t_out_item             n_out;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_load;
    logic                  w_shift;
    logic                  w_in_ready;
    t_cell_ctl             w_ctl;
    logic [VALUE_BITS-1:0] w_val [MAX_ITEMS];
    logic                  w_gt  [MAX_ITEMS];

    assign w_full   = r_count == CW'(MAX_ITEMS);
    assign w_accept = i_in_valid && w_in_ready;
    assign w_load   = !r_out_valid || i_out_ready;

    assign w_ctl.insert = w_accept && !w_full;
    assign w_ctl.shift  = w_shift;
    assign w_ctl.value  = i_in_data.value;

    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
            logic [VALUE_BITS-1:0] w_below_val;
            logic                  w_below_gt;
            logic [VALUE_BITS-1:0] w_above_val;
            if (g == 0) begin : g_first
                assign w_below_val = '0;
                assign w_below_gt  = 1'b0;
            end else begin : g_inner
                assign w_below_val = w_val[g-1];
                assign w_below_gt  = w_gt[g-1];
            end
            if (g == MAX_ITEMS - 1) begin : g_top
                assign w_above_val = '0;
            end else begin : g_lower
                assign w_above_val = w_val[g+1];
            end
            iss_cell #(
                .IDX(g),
                .CW (CW)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_count    (r_count),
                .i_below_val(w_below_val),
                .i_below_gt (w_below_gt),
                .i_above_val(w_above_val),
                .o_val      (w_val[g]),
                .o_gt       (w_gt[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (w_accept && i_in_data.last_item) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_shift && (r_count == CW'(1))) begin
                    n_state = ST_FILL;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_shift    = 1'b0;
        unique case (r_state)
            ST_FILL:  w_in_ready = 1'b1;
            ST_DRAIN: w_shift    = w_load && (r_count != '0);
            default: begin
                w_in_ready = 1'b0;
                w_shift    = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_drop      = r_drop;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        priority if (w_shift) begin
            n_count            = r_count - CW'(1);
            n_out.sorted_value = w_val[0];
            n_out.last_result  = r_count == CW'(1);
            n_out.overflow     = r_drop;
            n_out_valid        = 1'b1;
            if (r_count == CW'(1)) begin
                n_drop = 1'b0;
            end
        end else if (w_accept) begin
            if (w_full) begin
                n_drop = 1'b1;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_count != '0))
        else $error("drain with empty chain");

    a_drop_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full) |=> r_drop)
        else $error("dropped item did not raise flag");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_shift && (r_count == CW'(1))) |=>
            (r_state == ST_FILL && r_count == '0 && !r_drop
             && o_out_valid && o_out_data.last_result))
        else $error("run did not close cleanly");

endmodule
